[src/stopwatch_min_sec_ms_counter_macros.svh]
// assertion helpers shared by the checker
`ifndef STOPWATCH_MIN_SEC_MS_COUNTER_MACROS_SVH
`define STOPWATCH_MIN_SEC_MS_COUNTER_MACROS_SVH

// consequent checked in the same cycle
`define SWMSC_ASSERT_SAME(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("stopwatch check failed");

// consequent checked in the next cycle
`define SWMSC_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("stopwatch check failed");

`endif

[src/swmsc_pkg.sv]
package swmsc_pkg;

    localparam int unsigned MS_PER_SEC  = 1000;
    localparam int unsigned SEC_PER_MIN = 60;
    localparam int unsigned MIN_WRAP    = 60;

    // floor(x / 1000) = (x * RECIP_MS) >> RECIP_SHIFT, exact for 16-bit x
    localparam int unsigned RECIP_SHIFT = 26;
    localparam logic [16:0] RECIP_MS    = 17'd67109;

    localparam logic OP_TICK   = 1'b0;
    localparam logic OP_BUTTON = 1'b1;

    localparam logic [2:0] KEY_MODE     = 3'd0;
    localparam logic [2:0] KEY_CLEAR    = 3'd1;
    localparam logic [2:0] KEY_SETUP    = 3'd2;
    localparam logic [2:0] KEY_RUN_STOP = 3'd3;

    typedef enum logic [1:0] {
        CMD_NONE,
        CMD_TICK,
        CMD_CLEAR,
        CMD_TOGGLE
    } cmd_kind_t;

    typedef enum logic [1:0] {
        HND_ZERO,
        HND_ONE,
        HND_RUN
    } hnd_sel_t;

    // tick amount pre-split into ms / s / min digits
    typedef struct packed {
        cmd_kind_t   kind;
        hnd_sel_t    hnd;
        logic [9:0]  ms;
        logic [5:0]  sec;
        logic        min;
    } cmd_t;

endpackage

[src/swmsc_front.sv]
module swmsc_front
    import swmsc_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_ready,
    input  logic        opcode,
    input  logic [15:0] tick_ms,
    input  logic [2:0]  button_id,
    input  logic        button_released,
    output logic        cmd_valid,
    input  logic        cmd_ready,
    output cmd_t        cmd
);

    logic        stg_valid_reg;
    logic        stg_valid_next;
    cmd_kind_t   kind_reg;
    hnd_sel_t    hnd_reg;
    logic [15:0] tick_reg;
    logic [6:0]  quot_reg;

    cmd_kind_t   kind_in;
    hnd_sel_t    hnd_in;
    logic [32:0] prod;
    logic [16:0] q1000;
    logic [16:0] rem;
    logic [6:0]  sec_q;

    // request classification
    always_comb
    begin
        kind_in = CMD_NONE;
        hnd_in  = HND_ZERO;
        if (opcode == OP_TICK)
        begin
            kind_in = CMD_TICK;
        end
        else if (!button_released)
        begin
            hnd_in = HND_ONE;
        end
        else
        begin
            case (button_id)
                KEY_MODE:
                begin
                    hnd_in = HND_RUN;
                end
                KEY_CLEAR:
                begin
                    kind_in = CMD_CLEAR;
                    hnd_in  = HND_ONE;
                end
                KEY_SETUP:
                begin
                    hnd_in = HND_ONE;
                end
                KEY_RUN_STOP:
                begin
                    kind_in = CMD_TOGGLE;
                    hnd_in  = HND_ONE;
                end
                default:
                begin
                    hnd_in = HND_ZERO;
                end
            endcase
        end
    end

    assign prod = {17'd0, tick_ms} * {16'd0, RECIP_MS};

    assign in_ready       = !stg_valid_reg || cmd_ready;
    assign stg_valid_next = in_ready ? in_valid : stg_valid_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            stg_valid_reg <= 1'b0;
        end
        else
        begin
            stg_valid_reg <= stg_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_valid && in_ready)
        begin
            kind_reg <= kind_in;
            hnd_reg  <= hnd_in;
            tick_reg <= tick_ms;
            quot_reg <= prod[RECIP_SHIFT +: 7];
        end
    end

    // remainder via 1000 = 1024 - 16 - 8
    assign q1000 = ({10'd0, quot_reg} << 10) - ({10'd0, quot_reg} << 4)
                 - ({10'd0, quot_reg} << 3);
    assign rem   = {1'b0, tick_reg} - q1000;
    // whole seconds never exceed 65, so one subtract splits off the minute
    assign sec_q = (quot_reg >= 7'(SEC_PER_MIN)) ? quot_reg - 7'(SEC_PER_MIN) : quot_reg;

    assign cmd_valid = stg_valid_reg;
    assign cmd.kind  = kind_reg;
    assign cmd.hnd   = hnd_reg;
    assign cmd.ms    = rem[9:0];
    assign cmd.sec   = sec_q[5:0];
    assign cmd.min   = (quot_reg >= 7'(SEC_PER_MIN));

endmodule

[src/swmsc_queue.sv]
module swmsc_queue
    import swmsc_pkg::*;
#(
    parameter int DEPTH = 2
)
(
    input  logic clk,
    input  logic rst_n,
    input  logic push_valid,
    output logic push_ready,
    input  cmd_t push_data,
    output logic pop_valid,
    input  logic pop_ready,
    output cmd_t pop_data
);

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);

    cmd_t             mem_reg [DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg;
    logic [PTR_W-1:0] wr_ptr_next;
    logic [PTR_W-1:0] rd_ptr_reg;
    logic [PTR_W-1:0] rd_ptr_next;
    logic [CNT_W-1:0] count_reg;
    logic [CNT_W-1:0] count_next;
    logic             push;
    logic             pop;

    assign push_ready = (count_reg != CNT_W'(DEPTH));
    assign pop_valid  = (count_reg != '0);
    assign push       = push_valid && push_ready;
    assign pop        = pop_valid && pop_ready;
    assign pop_data   = mem_reg[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push)
        begin
            wr_ptr_next = (wr_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (pop)
        begin
            rd_ptr_next = (rd_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (push && !pop)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (pop && !push)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            mem_reg[wr_ptr_reg] <= push_data;
        end
    end

endmodule

[src/swmsc_back.sv]
module swmsc_back
    import swmsc_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       cmd_valid,
    output logic       cmd_ready,
    input  cmd_t       cmd,
    output logic       out_valid,
    input  logic       out_ready,
    output logic       handled,
    output logic [5:0] minutes_now,
    output logic [5:0] seconds_now,
    output logic [9:0] millis_now,
    output logic       is_running
);

    logic [5:0] min_reg;
    logic [5:0] min_next;
    logic [5:0] sec_reg;
    logic [5:0] sec_next;
    logic [9:0] ms_reg;
    logic [9:0] ms_next;
    logic       run_reg;
    logic       run_next;
    logic       out_valid_reg;
    logic       out_valid_next;
    logic       handled_reg;
    logic       handled_next;
    logic [5:0] min_out_reg;
    logic [5:0] sec_out_reg;
    logic [9:0] ms_out_reg;
    logic       run_out_reg;

    logic        fire;
    logic [10:0] ms_sum;
    logic        ms_c;
    logic [10:0] ms_adj;
    logic [6:0]  sec_sum;
    logic        sec_c;
    logic [6:0]  sec_adj;
    logic [6:0]  min_sum;
    logic [6:0]  min_adj;

    assign cmd_ready = !out_valid_reg || out_ready;
    assign fire      = cmd_valid && cmd_ready;

    // carry chain: each digit sum stays below twice its modulus
    assign ms_sum  = {1'b0, ms_reg} + {1'b0, cmd.ms};
    assign ms_c    = (ms_sum >= 11'(MS_PER_SEC));
    assign ms_adj  = ms_c ? ms_sum - 11'(MS_PER_SEC) : ms_sum;
    assign sec_sum = {1'b0, sec_reg} + {1'b0, cmd.sec} + {6'd0, ms_c};
    assign sec_c   = (sec_sum >= 7'(SEC_PER_MIN));
    assign sec_adj = sec_c ? sec_sum - 7'(SEC_PER_MIN) : sec_sum;
    assign min_sum = {1'b0, min_reg} + {6'd0, cmd.min} + {6'd0, sec_c};
    assign min_adj = (min_sum >= 7'(MIN_WRAP)) ? min_sum - 7'(MIN_WRAP) : min_sum;

    always_comb
    begin
        min_next = min_reg;
        sec_next = sec_reg;
        ms_next  = ms_reg;
        run_next = run_reg;
        if (fire)
        begin
            case (cmd.kind)
                CMD_TICK:
                begin
                    if (run_reg)
                    begin
                        min_next = min_adj[5:0];
                        sec_next = sec_adj[5:0];
                        ms_next  = ms_adj[9:0];
                    end
                end
                CMD_CLEAR:
                begin
                    if (!run_reg)
                    begin
                        min_next = '0;
                        sec_next = '0;
                        ms_next  = '0;
                    end
                end
                CMD_TOGGLE:
                begin
                    run_next = !run_reg;
                end
                default:
                begin
                    run_next = run_reg;
                end
            endcase
        end
    end

    always_comb
    begin
        case (cmd.hnd)
            HND_ONE:
            begin
                handled_next = 1'b1;
            end
            HND_RUN:
            begin
                handled_next = run_reg;
            end
            default:
            begin
                handled_next = 1'b0;
            end
        endcase
    end

    assign out_valid_next = fire ? 1'b1 : (out_ready ? 1'b0 : out_valid_reg);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            min_reg       <= '0;
            sec_reg       <= '0;
            ms_reg        <= '0;
            run_reg       <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            min_reg       <= min_next;
            sec_reg       <= sec_next;
            ms_reg        <= ms_next;
            run_reg       <= run_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (fire)
        begin
            handled_reg <= handled_next;
            min_out_reg <= min_next;
            sec_out_reg <= sec_next;
            ms_out_reg  <= ms_next;
            run_out_reg <= run_next;
        end
    end

    assign out_valid   = out_valid_reg;
    assign handled     = handled_reg;
    assign minutes_now = min_out_reg;
    assign seconds_now = sec_out_reg;
    assign millis_now  = ms_out_reg;
    assign is_running  = run_out_reg;

endmodule

[src/stopwatch_min_sec_ms_counter.sv]
// result path: classify reg, then the queue, then the result reg
// throughput: one item per cycle while out_ready holds; the back end updates the time combinationally
// the front splits each tick into ms/s/min digits so the back end only adds with carries
// reset (rst_n low, async): time 00:00.000, stopped, all stages and the queue empty
// stalls on the output back up through the queue to in_ready
module stopwatch_min_sec_ms_counter
    import swmsc_pkg::*;
#(
    parameter int QUEUE_DEPTH = 2
)
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_ready,
    input  logic        opcode,
    input  logic [15:0] tick_ms,
    input  logic [2:0]  button_id,
    input  logic        button_released,
    output logic        out_valid,
    input  logic        out_ready,
    output logic        handled,
    output logic [5:0]  minutes_now,
    output logic [5:0]  seconds_now,
    output logic [9:0]  millis_now,
    output logic        is_running
);

    logic fq_valid;
    logic fq_ready;
    cmd_t fq_cmd;
    logic qb_valid;
    logic qb_ready;
    cmd_t qb_cmd;

    swmsc_front u_front (
        .clk             (clk),
        .rst_n           (rst_n),
        .in_valid        (in_valid),
        .in_ready        (in_ready),
        .opcode          (opcode),
        .tick_ms         (tick_ms),
        .button_id       (button_id),
        .button_released (button_released),
        .cmd_valid       (fq_valid),
        .cmd_ready       (fq_ready),
        .cmd             (fq_cmd)
    );

    swmsc_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .clk        (clk),
        .rst_n      (rst_n),
        .push_valid (fq_valid),
        .push_ready (fq_ready),
        .push_data  (fq_cmd),
        .pop_valid  (qb_valid),
        .pop_ready  (qb_ready),
        .pop_data   (qb_cmd)
    );

    swmsc_back u_back (
        .clk         (clk),
        .rst_n       (rst_n),
        .cmd_valid   (qb_valid),
        .cmd_ready   (qb_ready),
        .cmd         (qb_cmd),
        .out_valid   (out_valid),
        .out_ready   (out_ready),
        .handled     (handled),
        .minutes_now (minutes_now),
        .seconds_now (seconds_now),
        .millis_now  (millis_now),
        .is_running  (is_running)
    );

endmodule

[src/swmsc_checker.sv]
`include "stopwatch_min_sec_ms_counter_macros.svh"

module swmsc_checker #(
    parameter int MAX_PENDING = 4
)
(
    input logic        clk,
    input logic        rst_n,
    input logic        in_valid,
    input logic        in_ready,
    input logic        out_valid,
    input logic        out_ready,
    input logic        handled,
    input logic [5:0]  minutes_now,
    input logic [5:0]  seconds_now,
    input logic [9:0]  millis_now,
    input logic        is_running
);

    localparam int CNT_W = $clog2(MAX_PENDING + 2);

    logic             in_acc;
    logic             out_acc;
    logic [CNT_W-1:0] pending_reg;
    logic [CNT_W-1:0] pending_next;
    logic             time_ok;
    logic [23:0]      reading;

    assign in_acc  = in_valid && in_ready;
    assign out_acc = out_valid && out_ready;

    assign time_ok = (minutes_now <= 6'd59) && (seconds_now <= 6'd59)
                  && (millis_now <= 10'd999);
    assign reading = {handled, minutes_now, seconds_now, millis_now, is_running};

    // requests taken but not yet answered
    always_comb
    begin
        pending_next = pending_reg;
        if (in_acc && !out_acc)
        begin
            pending_next = pending_reg + 1'b1;
        end
        else if (out_acc && !in_acc)
        begin
            pending_next = pending_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pending_reg <= '0;
        end
        else
        begin
            pending_reg <= pending_next;
        end
    end

    `SWMSC_ASSERT_SAME(a_time_in_range, out_valid, time_ok)
    `SWMSC_ASSERT_SAME(a_no_spurious_result, out_valid, pending_reg != '0)
    `SWMSC_ASSERT_SAME(a_pending_bounded, 1'b1, pending_reg <= CNT_W'(MAX_PENDING))
    `SWMSC_ASSERT_NEXT(a_stall_holds, out_valid && !out_ready, out_valid && $stable(reading))

endmodule

bind stopwatch_min_sec_ms_counter swmsc_checker #(
    .MAX_PENDING (QUEUE_DEPTH + 2)
) u_checker (.*);
